>>> hdl/jtr_pkg.sv
// shared types and constants for the json text reformatter
// no dependencies; imported by jtr_classify and json_text_reformatter_top

package jtr_pkg;

	localparam int CHAR_W  = 8;
	localparam int DEPTH_W = 4;

	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              stream_end;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              run_last;
	} out_item_t;

	// parser state carried between bytes
	typedef struct packed {
		logic               inside_string;
		logic               escape_pending;
		logic               open_pending;
		logic               kept_valid;
		logic [CHAR_W-1:0]  previous_kept;
		logic [DEPTH_W-1:0] nest_depth;
	} parse_state_t;

	// what the emitter has to produce for one input byte
	typedef struct packed {
		logic kept;
		logic brk_open;
		logic brk_close;
		logic post_comma;
		logic post_colon;
	} plan_t;

endpackage

>>> hdl/jtr_classify.sv
// byte classifier: decides the output plan and next parser state for one byte
// depends on jtr_pkg

module jtr_classify
	import jtr_pkg::*;
#(
	parameter int INDENT_WIDTH = 2,
	parameter int MAX_DEPTH    = 15
) (
	input  logic [CHAR_W-1:0]                                   ch,
	input  logic                                                pretty,
	input  parse_state_t                                        cur,
	output plan_t                                               plan,
	output parse_state_t                                        nxt,
	output logic [$clog2(MAX_DEPTH*INDENT_WIDTH+2)-1:0]         sp_open,
	output logic [$clog2(MAX_DEPTH*INDENT_WIDTH+2)-1:0]         sp_close
);

	localparam int SP_W   = $clog2(MAX_DEPTH*INDENT_WIDTH+2);
	localparam int PROD_W = DEPTH_W + 2;

	logic               is_ws;
	logic               kept;
	logic               empty_pair;
	logic               is_opener;
	logic               is_closer;
	logic [CHAR_W-1:0]  match_opener;
	logic [DEPTH_W-1:0] d1;
	logic [DEPTH_W-1:0] d2;
	logic [PROD_W-1:0]  prod1;
	logic [PROD_W-1:0]  prod2;

	always_comb begin
		is_ws = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
		kept  = cur.inside_string || !is_ws;
		is_opener = (ch == CH_LBRACE) || (ch == CH_LBRACK);
		is_closer = (ch == CH_RBRACE) || (ch == CH_RBRACK);
		match_opener = (ch == CH_RBRACE) ? CH_LBRACE : CH_LBRACK;
		empty_pair = ((cur.previous_kept == CH_LBRACE) && (ch == CH_RBRACE)) ||
		             ((cur.previous_kept == CH_LBRACK) && (ch == CH_RBRACK));

		plan = '0;
		nxt  = cur;
		plan.kept = kept;

		if (kept) begin
			// string and escape tracking, same in both modes
			if (cur.inside_string) begin
				if (cur.escape_pending) begin
					nxt.escape_pending = 1'b0;
				end else if (ch == CH_BSLASH) begin
					nxt.escape_pending = 1'b1;
				end else if (ch == CH_QUOTE) begin
					nxt.inside_string = 1'b0;
				end
			end else if (ch == CH_QUOTE) begin
				nxt.inside_string = 1'b1;
			end

			nxt.open_pending = 1'b0;
			if (pretty) begin
				plan.brk_open = cur.open_pending && !empty_pair;
				if (!cur.inside_string) begin
					nxt.open_pending = is_opener;
					plan.brk_close   = is_closer && cur.kept_valid &&
					                   (cur.previous_kept != match_opener);
					plan.post_comma  = (ch == CH_COMMA);
					plan.post_colon  = (ch == CH_COLON);
				end
			end

			nxt.previous_kept = ch;
			nxt.kept_valid    = 1'b1;
		end

		// depth after the opener break, then after the closer break
		d1 = cur.nest_depth;
		if (plan.brk_open && (cur.nest_depth < DEPTH_W'(MAX_DEPTH))) begin
			d1 = cur.nest_depth + DEPTH_W'(1);
		end
		d2 = d1;
		if (plan.brk_close && (d1 != '0)) begin
			d2 = d1 - DEPTH_W'(1);
		end
		nxt.nest_depth = d2;

		prod1    = PROD_W'(d1) * PROD_W'(INDENT_WIDTH);
		prod2    = PROD_W'(d2) * PROD_W'(INDENT_WIDTH);
		sp_open  = prod1[SP_W-1:0];
		sp_close = prod2[SP_W-1:0];
	end

endmodule

>>> hdl/json_text_reformatter_top.sv
// json text reformatter top level: input/output channels, emit sequencer
// depends on jtr_pkg and jtr_classify

// Usage
//   src channel: one byte of JSON text (in_char) plus stream_end per transfer;
//     a transfer happens on a rising edge with src_valid high and src_stall low.
//   dst channel: one output byte (out_char) plus run_last per transfer;
//     run_last marks the final byte caused by the current input byte.
//   cfg channel: one-bit pretty_enable, written when cfg_valid and cfg_ready
//     are both high; write it only while the block is idle.
// Timing
//   an input byte producing n output bytes keeps src_stall high after its
//   transfer until the emit sequencer has sent its last byte (n is 0 when
//   the byte is dropped); n is at most 63. the emit sequencer sends one
//   byte per cycle while dst_stall does not hold it, and counts indentation
//   spaces down with a single counter. the first output byte passes through
//   the plan registers before it reaches the output register.
// Reset and stall
//   arst_n clears the parser state and sets pretty_enable; a held dst_stall
//   freezes a full output register and the sequencer, and src_stall stays high
//   while the sequencer still has bytes of the current input to send.

module json_text_reformatter_top
	import jtr_pkg::*;
#(
	parameter int INDENT_WIDTH = 2,
	parameter int MAX_DEPTH    = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_data,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	localparam int SP_W = $clog2(MAX_DEPTH*INDENT_WIDTH+2);

	// parser state and mode
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         pretty_q;
	plan_t        plan;
	logic [SP_W-1:0] sp_open;
	logic [SP_W-1:0] sp_close;

	// pending work for the emitter
	logic              brk1_q, brk2_q, byte_q, comma_q, colon_q;
	logic              brk1_n, brk2_n, byte_n, comma_n, colon_n;
	logic [CHAR_W-1:0] char_q;
	logic [SP_W-1:0]   sp1_q, sp2_q;
	logic [SP_W-1:0]   sp_cnt_q, sp_nxt;

	// output register
	logic              out_valid_q;
	out_item_t         out_q;

	logic              busy;
	logic              accept;
	logic              fire;
	logic [CHAR_W-1:0] emit_ch;
	logic              emit_last;

	jtr_classify #(
		.INDENT_WIDTH(INDENT_WIDTH),
		.MAX_DEPTH   (MAX_DEPTH)
	) u_classify (
		.ch      (src_data.in_char),
		.pretty  (pretty_q),
		.cur     (state_q),
		.plan    (plan),
		.nxt     (state_nxt),
		.sp_open (sp_open),
		.sp_close(sp_close)
	);

	// busy while any byte of the current plan is still to go
	assign busy      = (sp_cnt_q != '0) || brk1_q || brk2_q || byte_q || comma_q || colon_q;
	assign src_stall = busy;
	assign accept    = src_valid && !busy;
	assign fire      = busy && (!out_valid_q || !dst_stall);
	assign cfg_ready = 1'b1;
	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

	// pick the next byte: opener break, closer break, the byte, then comma or colon tail
	always_comb begin
		brk1_n  = brk1_q;
		brk2_n  = brk2_q;
		byte_n  = byte_q;
		comma_n = comma_q;
		colon_n = colon_q;
		sp_nxt  = sp_cnt_q;
		emit_ch = CH_SPACE;
		if (sp_cnt_q != '0) begin
			sp_nxt = sp_cnt_q - SP_W'(1);
		end else if (brk1_q) begin
			emit_ch = CH_LF;
			brk1_n  = 1'b0;
			sp_nxt  = sp1_q;
		end else if (brk2_q) begin
			emit_ch = CH_LF;
			brk2_n  = 1'b0;
			sp_nxt  = sp2_q;
		end else if (byte_q) begin
			emit_ch = char_q;
			byte_n  = 1'b0;
		end else if (comma_q) begin
			emit_ch = CH_LF;
			comma_n = 1'b0;
			sp_nxt  = sp2_q;
		end else begin
			colon_n = 1'b0;
		end
		emit_last = (sp_nxt == '0) && !(brk1_n || brk2_n || byte_n || comma_n || colon_n);
	end

	// parser state and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			pretty_q <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pretty_q <= cfg_data;
			end
			if (accept) begin
				// stream end returns the parser to its reset state
				state_q <= src_data.stream_end ? '0 : state_nxt;
			end
		end
	end

	// emit sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk1_q   <= 1'b0;
			brk2_q   <= 1'b0;
			byte_q   <= 1'b0;
			comma_q  <= 1'b0;
			colon_q  <= 1'b0;
			sp_cnt_q <= '0;
		end else if (accept) begin
			brk1_q   <= plan.brk_open;
			brk2_q   <= plan.brk_close;
			byte_q   <= plan.kept;
			comma_q  <= plan.post_comma;
			colon_q  <= plan.post_colon;
			sp_cnt_q <= '0;
		end else if (fire) begin
			brk1_q   <= brk1_n;
			brk2_q   <= brk2_n;
			byte_q   <= byte_n;
			comma_q  <= comma_n;
			colon_q  <= colon_n;
			sp_cnt_q <= sp_nxt;
		end
	end

	// plan payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= src_data.in_char;
			sp1_q  <= sp_open;
			sp2_q  <= sp_close;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.out_char <= emit_ch;
			out_q.run_last <= emit_last;
		end
	end

`ifndef SYNTHESIS
	// depth never passes its ceiling
	a_depth_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.nest_depth <= DEPTH_W'(MAX_DEPTH))
		else $error("nest depth above limit");

	// opener break always goes first, so no space run can be active before it
	a_brk1_first: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_cnt_q != '0) |-> !brk1_q)
		else $error("space run before opener break");

	// an escape only exists inside a string, and no opener is pending there
	a_string_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!state_q.escape_pending || state_q.inside_string) &&
		(!state_q.inside_string || !state_q.open_pending))
		else $error("inconsistent string state");

	// a byte is emitted only while work is pending, never on an input transfer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !out_valid_q || $stable(out_q) || $past(fire))
		else $error("output changed without emit");
`endif

endmodule
